FILE: hdl/sbrot_pkg.sv
// shared types, orientation table and coefficient constants for the board rotation core
package sbrot_pkg;

  typedef logic [5:0]  orient_code_t;
  typedef logic [1:0]  status_t;
  typedef logic [3:0]  coef_idx_t;
  typedef logic [35:0] rot_sel_t;
  typedef logic [15:0][63:0] coef_set_t;

  localparam orient_code_t NUM_CODES   = 6'd42;
  localparam orient_code_t CODE_CUSTOM = 6'd42;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_CUSTOM  = 2'd1;
  localparam status_t STATUS_INVALID = 2'd2;

  localparam longint unsigned NANO_ONE = 64'd1000000000;

  // matrix entries, one nibble each, out x row first
  localparam rot_sel_t ROT_IDENTITY = 36'h100010001;

  // coefficient values in units of 1e-9
  function automatic longint coef_nano(coef_idx_t idx);
    longint v;
    case (idx)
      4'd0:    v = 64'sd0;
      4'd1:    v = 64'sd1000000000;
      4'd2:    v = -64'sd1000000000;
      4'd3:    v = 64'sd707106781;
      4'd4:    v = -64'sd707106781;
      4'd5:    v = 64'sd143039000;
      4'd6:    v = 64'sd368776000;
      4'd7:    v = -64'sd918446000;
      4'd8:    v = -64'sd332133000;
      4'd9:    v = -64'sd856289000;
      4'd10:   v = -64'sd395546000;
      4'd11:   v = -64'sd932324000;
      4'd12:   v = 64'sd361625000;
      4'd13:   v = 64'sd121869343;
      4'd14:   v = -64'sd121869343;
      default: v = 64'sd992546152;
    endcase
    return v;
  endfunction

  // all sixteen coefficients in fixed point, magnitude rounded half up, sign after
  function automatic coef_set_t coef_all(int frac_bits);
    coef_set_t      res;
    longint         v;
    longint unsigned mag;
    longint unsigned q;
    for (int i = 0; i < 16; i++) begin
      v   = coef_nano(coef_idx_t'(i));
      mag = (v < 0) ? longint'(-v) : longint'(v);
      q   = ((mag << frac_bits) + NANO_ONE / 2) / NANO_ONE;
      res[i] = (v < 0) ? (~q + 64'd1) : q;
    end
    return res;
  endfunction

  function automatic rot_sel_t rot_sel(orient_code_t code);
    rot_sel_t s;
    unique case (code)
      6'd0:    s = 36'h100010001;
      6'd1:    s = 36'h340330001;
      6'd2:    s = 36'h020100001;
      6'd3:    s = 36'h440340001;
      6'd4:    s = 36'h200020001;
      6'd5:    s = 36'h430440001;
      6'd6:    s = 36'h010200001;
      6'd7:    s = 36'h330430001;
      6'd8:    s = 36'h100020002;
      6'd9:    s = 36'h330340002;
      6'd10:   s = 36'h010100002;
      6'd11:   s = 36'h430330002;
      6'd12:   s = 36'h200010002;
      6'd13:   s = 36'h440430002;
      6'd14:   s = 36'h020200002;
      6'd15:   s = 36'h340440002;
      6'd16:   s = 36'h100002010;
      6'd17:   s = 36'h303304010;
      6'd18:   s = 36'h001100010;
      6'd19:   s = 36'h403303010;
      6'd20:   s = 36'h100001020;
      6'd21:   s = 36'h304303020;
      6'd22:   s = 36'h002100020;
      6'd23:   s = 36'h404304020;
      6'd24:   s = 36'h001010200;
      6'd25:   s = 36'h002010100;
      6'd26:   s = 36'h020200002;
      6'd27:   s = 36'h010100002;
      6'd28:   s = 36'h010002200;
      6'd29:   s = 36'h002020200;
      6'd30:   s = 36'h020001200;
      6'd31:   s = 36'h200002020;
      6'd32:   s = 36'h200001010;
      6'd33:   s = 36'h020002100;
      6'd34:   s = 36'h001020100;
      6'd35:   s = 36'h010001100;
      6'd36:   s = 36'h001200020;
      6'd37:   s = 36'h002200010;
      6'd38:   s = 36'h56789ABC0;
      6'd39:   s = 36'h304010303;
      6'd40:   s = 36'h340002330;
      6'd41:   s = 36'hF0D010E0F;
      default: s = ROT_IDENTITY;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/sensor_board_rotation_core.sv
// top level: board orientation rotation of three-axis sensor samples
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, in_x, in_y, in_z      | in
//  result  | out_valid, out_ready, out_x/y/z, out_status | out
//  config  | cfg_we, cfg_orientation_code              | in
//
// one transaction per cycle unless the result stalls; the input register loads at the
// accepting edge, and the multiply and round load the output register once it is free.
// the coefficient matrix is decoded and registered on a config write. reset clears both
// stages and selects the identity orientation. a stalled result holds in the output
// register while the input register still takes one more
module sensor_board_rotation_core import sbrot_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_x,
  input  logic signed [SAMPLE_BITS-1:0] in_y,
  input  logic signed [SAMPLE_BITS-1:0] in_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS:0]   out_x,
  output logic signed [SAMPLE_BITS:0]   out_y,
  output logic signed [SAMPLE_BITS:0]   out_z,
  output logic [1:0]                    out_status,
  input  logic                          cfg_we,
  input  logic [5:0]                    cfg_orientation_code
);

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam coef_set_t COEF_TAB = coef_all(COEF_FRAC_BITS);

  typedef logic signed [CW-1:0] coef_t;

  orient_code_t code_r;
  coef_t        coef_r   [9];
  coef_t        coef_nxt [9];
  coef_t        coef_rst [9];
  rot_sel_t     sel_cfg;
  status_t      status_cur;

  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_x_r;
  logic signed [SAMPLE_BITS-1:0] s1_y_r;
  logic signed [SAMPLE_BITS-1:0] s1_z_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS:0]   out_x_r;
  logic signed [SAMPLE_BITS:0]   out_y_r;
  logic signed [SAMPLE_BITS:0]   out_z_r;
  status_t                       out_status_r;

  logic signed [SAMPLE_BITS:0]   rot_x;
  logic signed [SAMPLE_BITS:0]   rot_y;
  logic signed [SAMPLE_BITS:0]   rot_z;

  logic in_fire;
  logic out_take;
  logic s1_move;

  // coefficient decode for config writes and reset
  assign sel_cfg = rot_sel(cfg_orientation_code);

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      coef_nxt[k] = COEF_TAB[sel_cfg[35-4*k -: 4]][CW-1:0];
      coef_rst[k] = COEF_TAB[ROT_IDENTITY[35-4*k -: 4]][CW-1:0];
    end
  end

  always_comb begin
    if (code_r < NUM_CODES) begin
      status_cur = STATUS_OK;
    end else if (code_r == CODE_CUSTOM) begin
      status_cur = STATUS_CUSTOM;
    end else begin
      status_cur = STATUS_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
      for (int k = 0; k < 9; k++) begin
        coef_r[k] <= coef_rst[k];
      end
    end else if (cfg_we) begin
      code_r <= cfg_orientation_code;
      for (int k = 0; k < 9; k++) begin
        coef_r[k] <= coef_nxt[k];
      end
    end
  end

  // handshake
  assign out_take = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_take;
  assign in_ready = !s1_valid_r || out_take;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r <= in_x;
      s1_y_r <= in_y;
      s1_z_r <= in_z;
    end
    if (s1_move) begin
      out_x_r      <= rot_x;
      out_y_r      <= rot_y;
      out_z_r      <= rot_z;
      out_status_r <= status_cur;
    end
  end

  sbrot_row #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_row_x (
    .coef_a (coef_r[0]),
    .coef_b (coef_r[1]),
    .coef_c (coef_r[2]),
    .smp_a  (s1_x_r),
    .smp_b  (s1_y_r),
    .smp_c  (s1_z_r),
    .result (rot_x)
  );

  sbrot_row #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_row_y (
    .coef_a (coef_r[3]),
    .coef_b (coef_r[4]),
    .coef_c (coef_r[5]),
    .smp_a  (s1_x_r),
    .smp_b  (s1_y_r),
    .smp_c  (s1_z_r),
    .result (rot_y)
  );

  sbrot_row #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_row_z (
    .coef_a (coef_r[6]),
    .coef_b (coef_r[7]),
    .coef_c (coef_r[8]),
    .smp_a  (s1_x_r),
    .smp_b  (s1_y_r),
    .smp_c  (s1_z_r),
    .result (rot_z)
  );

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_z      = out_z_r;
  assign out_status = out_status_r;

  // accepted transaction always lands in the input register
  a_in_to_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted transaction not held in input register");

  // full input register behind a stalled result blocks the input
  a_stall_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

  // a moving item always produces a result next cycle
  a_s1_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("item lost between input and output register");

  // valid codes never report an error status
  a_status_ok : assert property (@(posedge clk) disable iff (!rst_n)
    code_r < NUM_CODES |-> status_cur == STATUS_OK)
    else $error("error status for a supported orientation");

endmodule

FILE: hdl/sbrot_row.sv
// one output axis: three products, sum, round half up and saturate
module sbrot_row import sbrot_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic signed [COEF_FRAC_BITS+1:0] coef_a,
  input  logic signed [COEF_FRAC_BITS+1:0] coef_b,
  input  logic signed [COEF_FRAC_BITS+1:0] coef_c,
  input  logic signed [SAMPLE_BITS-1:0]    smp_a,
  input  logic signed [SAMPLE_BITS-1:0]    smp_b,
  input  logic signed [SAMPLE_BITS-1:0]    smp_c,
  output logic signed [SAMPLE_BITS:0]      result
);

  localparam int PW = SAMPLE_BITS + COEF_FRAC_BITS + 2;
  localparam int AW = PW + 2;
  localparam int RW = AW - COEF_FRAC_BITS;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (COEF_FRAC_BITS - 1);

  logic signed [PW-1:0] prod_a;
  logic signed [PW-1:0] prod_b;
  logic signed [PW-1:0] prod_c;
  logic signed [AW-1:0] acc;
  logic signed [RW-1:0] rnd;
  logic                 ovf;

  assign prod_a = PW'(coef_a) * PW'(smp_a);
  assign prod_b = PW'(coef_b) * PW'(smp_b);
  assign prod_c = PW'(coef_c) * PW'(smp_c);

  assign acc = AW'(prod_a) + AW'(prod_b) + AW'(prod_c) + HALF;
  assign rnd = $signed(acc[AW-1:COEF_FRAC_BITS]);

  // top bits must all match the sign to fit the output width
  assign ovf = (rnd[RW-1:SAMPLE_BITS] != {(RW-SAMPLE_BITS){rnd[RW-1]}});

  always_comb begin
    if (ovf) begin
      result = rnd[RW-1] ? {1'b1, {SAMPLE_BITS{1'b0}}} : {1'b0, {SAMPLE_BITS{1'b1}}};
    end else begin
      result = rnd[SAMPLE_BITS:0];
    end
  end

endmodule

FILE: sim/sbrot_rotation_check.sv
// checker for the board rotation core: predicts each rotated sample and compares the results
module sbrot_rotation_check import sbrot_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic signed [15:0]  in_x,
  input  logic signed [15:0]  in_y,
  input  logic signed [15:0]  in_z,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [16:0]  out_x,
  input  logic signed [16:0]  out_y,
  input  logic signed [16:0]  out_z,
  input  logic [1:0]          out_status,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_orientation_code,
  output int                  mismatches,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam longint NANO_UNIT = 64'sd1000000000;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
    status_t            status;
  } rotated_t;

  localparam longint NANO_VAL [16] = '{
    64'sd0, 64'sd1000000000, -64'sd1000000000, 64'sd707106781, -64'sd707106781,
    64'sd143039000, 64'sd368776000, -64'sd918446000, -64'sd332133000,
    -64'sd856289000, -64'sd395546000, -64'sd932324000, 64'sd361625000,
    64'sd121869343, -64'sd121869343, 64'sd992546152
  };

  // one nibble per matrix entry, out x row in the top three nibbles
  localparam logic [35:0] MATRIX_NIBBLES [42] = '{
    36'h100010001, 36'h340330001, 36'h020100001, 36'h440340001, 36'h200020001,
    36'h430440001, 36'h010200001, 36'h330430001, 36'h100020002, 36'h330340002,
    36'h010100002, 36'h430330002, 36'h200010002, 36'h440430002, 36'h020200002,
    36'h340440002, 36'h100002010, 36'h303304010, 36'h001100010, 36'h403303010,
    36'h100001020, 36'h304303020, 36'h002100020, 36'h404304020, 36'h001010200,
    36'h002010100, 36'h020200002, 36'h010100002, 36'h010002200, 36'h002020200,
    36'h020001200, 36'h200002020, 36'h200001010, 36'h020002100, 36'h001020100,
    36'h010001100, 36'h001200020, 36'h002200010, 36'h56789ABC0, 36'h304010303,
    36'h340002330, 36'hF0D010E0F
  };

  orient_code_t orientation;
  rotated_t     rotated_q [$];
  rotated_t     want;

  function automatic rotated_t rotate_sample(orient_code_t code, logic signed [15:0] sx,
                                             logic signed [15:0] sy, logic signed [15:0] sz);
    rotated_t           r;
    logic [35:0]        m;
    logic [3:0]         nib;
    logic signed [16:0] axis [3];
    longint             s [3];
    longint             nano;
    longint             mag;
    longint             coef;
    longint             acc;
    longint             v;
    s[0] = sx;
    s[1] = sy;
    s[2] = sz;
    if (code < NUM_CODES) begin
      m = MATRIX_NIBBLES[code];
      r.status = STATUS_OK;
    end else begin
      m = MATRIX_NIBBLES[0];
      r.status = (code == CODE_CUSTOM) ? STATUS_CUSTOM : STATUS_INVALID;
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        nib  = m[35 - 4 * (3 * i + j) -: 4];
        nano = NANO_VAL[nib];
        mag  = (nano < 0) ? -nano : nano;
        coef = ((mag <<< FRAC_BITS) + NANO_UNIT / 2) / NANO_UNIT;
        if (nano < 0) begin
          coef = -coef;
        end
        acc += coef * s[j];
      end
      v = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (v > 65535) begin
        v = 65535;
      end
      if (v < -65536) begin
        v = -65536;
      end
      axis[i] = v[16:0];
    end
    r.x = axis[0];
    r.y = axis[1];
    r.z = axis[2];
    return r;
  endfunction

  task automatic check_axis(string label, logic signed [16:0] exp_val,
                            logic signed [16:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t %s mismatch: expected %0d got %0d", $time, label, exp_val, got_val);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      orientation <= '0;
      rotated_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got x=%0d y=%0d z=%0d status=%0d",
                   $time, out_x, out_y, out_z, out_status);
          mismatches++;
        end else begin
          want = rotated_q.pop_front();
          check_axis("out_x", want.x, out_x);
          check_axis("out_y", want.y, out_y);
          check_axis("out_z", want.z, out_z);
          check_axis("out_status", 17'(want.status), 17'(out_status));
        end
      end
      if (in_valid && in_ready) begin
        rotated_q.push_back(rotate_sample(orientation, in_x, in_y, in_z));
      end
      if (cfg_we) begin
        orientation <= cfg_orientation_code;
      end
    end
    pending <= rotated_q.size();
  end

endmodule

FILE: sim/sensor_board_rotation_core_test.sv
// testbench top for the board rotation core: stimulus, config phases and verdict
module sensor_board_rotation_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sbrot_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam logic signed [15:0] S_MAX = 16'sh7fff;
  localparam logic signed [15:0] S_MIN = 16'sh8000;
  localparam orient_code_t CODE_NONE      = 6'd0;
  localparam orient_code_t CODE_YAW_45    = 6'd1;
  localparam orient_code_t CODE_TILTED    = 6'd38;
  localparam orient_code_t CODE_PITCH_7   = 6'd41;
  localparam orient_code_t CODE_INV_FIRST = CODE_CUSTOM + 6'd1;
  localparam orient_code_t CODE_INV_LAST  = 6'd63;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_x = '0;
  logic signed [15:0] in_y = '0;
  logic signed [15:0] in_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] out_x;
  logic signed [16:0] out_y;
  logic signed [16:0] out_z;
  logic [1:0]         out_status;
  logic               cfg_we = 1'b0;
  orient_code_t       cfg_orientation_code = '0;

  int mismatches;
  int pending;
  int quiet_cycles = 0;
  int idle_odds = 0;
  bit no_idle = 1'b0;

  always #6 clk = ~clk;

  sensor_board_rotation_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_x                 (in_x),
    .in_y                 (in_y),
    .in_z                 (in_z),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_x                (out_x),
    .out_y                (out_y),
    .out_z                (out_z),
    .out_status           (out_status),
    .cfg_we               (cfg_we),
    .cfg_orientation_code (cfg_orientation_code)
  );

  sbrot_rotation_check u_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_x                 (in_x),
    .in_y                 (in_y),
    .in_z                 (in_z),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_x                (out_x),
    .out_y                (out_y),
    .out_z                (out_z),
    .out_status           (out_status),
    .cfg_we               (cfg_we),
    .cfg_orientation_code (cfg_orientation_code),
    .mismatches           (mismatches),
    .pending              (pending)
  );

  task automatic push_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    in_valid <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold the sender until every transaction in flight has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_orientation(orient_code_t code);
    drain();
    cfg_we <= 1'b1;
    cfg_orientation_code <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_sample();
    logic signed [15:0] v [3];
    int mode;
    for (int k = 0; k < 3; k++) begin
      mode = $urandom_range(0, 19);
      if (mode < 14) begin
        v[k] = 16'($urandom);
      end else if (mode < 17) begin
        v[k] = 16'(int'($urandom_range(0, 64)) - 32);
      end else begin
        case ($urandom_range(0, 3))
          0: v[k] = S_MAX;
          1: v[k] = S_MIN;
          2: v[k] = 16'sh4000;
          default: v[k] = 16'shc000;
        endcase
      end
    end
    push_sample(v[0], v[1], v[2]);
  endtask

  task automatic random_run(int count);
    repeat (count) begin
      if (!no_idle && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        pause_input($urandom_range(1, 12));
      end
      random_sample();
    end
  endtask

  task automatic pick_idle_odds();
    idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
  endtask

  initial begin
    forever begin
      if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int count;
    orient_code_t code;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset orientation is identity
    push_sample(S_MAX, S_MAX, S_MAX);
    push_sample(S_MIN, S_MIN, S_MIN);
    push_sample(16'sd0, 16'sd0, 16'sd0);
    push_sample(S_MIN, S_MAX, -16'sd1);

    // half-unit ties under the root-two coefficients
    set_orientation(CODE_YAW_45);
    push_sample(16'sd16384, -16'sd16384, 16'sd0);
    push_sample(-16'sd16384, 16'sd16384, 16'sd1);
    push_sample(S_MIN, 16'sd0, S_MIN);
    push_sample(S_MAX, S_MIN, S_MAX);

    set_orientation(CODE_TILTED);
    push_sample(S_MAX, S_MIN, S_MAX);
    push_sample(S_MIN, S_MAX, S_MIN);

    set_orientation(CODE_PITCH_7);
    push_sample(S_MAX, S_MIN, S_MAX);
    push_sample(S_MIN, S_MIN, S_MIN);

    set_orientation(CODE_CUSTOM);
    push_sample(S_MIN, S_MAX, 16'sd7);
    set_orientation(CODE_INV_FIRST);
    push_sample(16'sd1, 16'sd2, 16'sd3);
    set_orientation(CODE_INV_LAST);
    push_sample(S_MAX, S_MIN, -16'sd2);

    // every orientation code in turn
    for (int k = 0; k < 64; k++) begin
      set_orientation(orient_code_t'(k));
      pick_idle_odds();
      random_run($urandom_range(8, 16));
    end

    // random phases, with the sender held until all results are back now and then
    sent = 0;
    while (sent < 450) begin
      case ($urandom_range(0, 7))
        0: code = CODE_NONE;
        1: code = CODE_PITCH_7;
        2: code = CODE_CUSTOM;
        3: code = CODE_INV_LAST;
        default: code = orient_code_t'($urandom_range(0, 63));
      endcase
      set_orientation(code);
      pick_idle_odds();
      count = $urandom_range(10, 60);
      if (sent == 0 || $urandom_range(0, 3) == 0) begin
        random_run(count / 2);
        drain();
        random_run(count - count / 2);
      end else begin
        random_run(count);
      end
      sent += count;
    end

    // last part at full rate on both sides
    no_idle = 1'b1;
    set_orientation(orient_code_t'($urandom_range(0, 41)));
    random_run(150);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sensor_board_rotation_core.f
hdl/sbrot_pkg.sv
hdl/sbrot_row.sv
hdl/sensor_board_rotation_core.sv
sim/sbrot_rotation_check.sv
sim/sensor_board_rotation_core_test.sv
